/* hdl/iqrmbd_pkg.sv */
// ----------------------------------------------------------------------------
// iqrmbd_pkg
// Shared widths, constants and register indexes of the quarter-rate mixer and
// boxcar decimator.
// ----------------------------------------------------------------------------
package iqrmbd_pkg;

   localparam int BYTE_W   = 8;
   localparam int SUM_W    = 16;
   localparam int DECIM_W  = 9;
   localparam int COUNT_W  = 8;
   localparam int PHASE_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [SUM_W-1:0]   MID_CODE    = 16'd127;
   localparam logic [DECIM_W-1:0] DECIM_RESET = 9'd42;
   localparam logic [DECIM_W-1:0] DECIM_MIN   = 9'd1;
   localparam logic [DECIM_W-1:0] DECIM_MAX   = 9'd256;

   // rotation factors 1, j, -1, -j
   localparam logic [PHASE_W-1:0] PHASE_ONE     = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_J       = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_NEG_ONE = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_NEG_J   = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DECIM_FACTOR    = 1'b0,
      CSR_ROTATION_BYPASS = 1'b1
   } csr_index_type;

   typedef logic [BYTE_W-1:0] byte_type;

endpackage

/* hdl/iqrmbd_rotator.sv */
// ----------------------------------------------------------------------------
// iqrmbd_rotator
// Multiplies one offset-binary I/Q byte pair by 1, j, -1 or -j. Negation is
// the byte complement.
// ----------------------------------------------------------------------------
module iqrmbd_rotator
(
   input  logic [iqrmbd_pkg::PHASE_W-1:0] phase,
   input  logic                           bypass,
   input  iqrmbd_pkg::byte_type           raw_i,
   input  iqrmbd_pkg::byte_type           raw_q,
   output iqrmbd_pkg::byte_type           rot_i,
   output iqrmbd_pkg::byte_type           rot_q
);
   import iqrmbd_pkg::*;

   always_comb begin
      rot_i = raw_i;
      rot_q = raw_q;
      if (!bypass) begin
         case (phase)
            PHASE_ONE: begin
               rot_i = raw_i;
               rot_q = raw_q;
            end
            PHASE_J: begin
               rot_i = ~raw_q;
               rot_q = raw_i;
            end
            PHASE_NEG_ONE: begin
               rot_i = ~raw_i;
               rot_q = ~raw_q;
            end
            PHASE_NEG_J: begin
               rot_i = raw_q;
               rot_q = ~raw_i;
            end
            default: begin
               rot_i = raw_i;
               rot_q = raw_q;
            end
         endcase
      end
   end

endmodule

/* hdl/iq_quarter_rate_mix_boxcar_decimator.sv */
// ----------------------------------------------------------------------------
// iq_quarter_rate_mix_boxcar_decimator
// Quarter-rate rotation of raw I/Q bytes followed by a boxcar sum and
// decimation; one sum pair out per decim_factor samples in.
// ----------------------------------------------------------------------------
// Output: the sum pair is registered and appears in the cycle after the sample that closes a block.
// Throughput: one sample per cycle while the input is not stalled; the accumulator adds, count and phase are the loops.
// Input stalls only while a finished sum pair is held and the output stalls.
// Reset (synchronous): accumulators, count and phase cleared, decim_factor 42,
// rotation enabled, output empty.
// ----------------------------------------------------------------------------
module iq_quarter_rate_mix_boxcar_decimator
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [iqrmbd_pkg::BYTE_W-1:0]    req_raw_i,
   input  logic [iqrmbd_pkg::BYTE_W-1:0]    req_raw_q,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [iqrmbd_pkg::SUM_W-1:0] rsp_sum_i,
   output logic signed [iqrmbd_pkg::SUM_W-1:0] rsp_sum_q,
   input  logic                             csr_write,
   input  logic [iqrmbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [iqrmbd_pkg::DECIM_W-1:0]   csr_wdata
);
   import iqrmbd_pkg::*;

   logic [DECIM_W-1:0] decim_ff, decim_in;
   logic               bypass_ff, bypass_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [SUM_W-1:0]   acc_i_ff, acc_i_in;
   logic [SUM_W-1:0]   acc_q_ff, acc_q_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   sum_i_ff, sum_i_in;
   logic [SUM_W-1:0]   sum_q_ff, sum_q_in;

   byte_type           rot_i;
   byte_type           rot_q;
   logic               accept;
   logic [SUM_W-1:0]   next_i;
   logic [SUM_W-1:0]   next_q;
   logic [DECIM_W-1:0] done;
   logic               block_end;

   iqrmbd_rotator u_rotator (
      .phase  (phase_ff),
      .bypass (bypass_ff),
      .raw_i  (req_raw_i),
      .raw_q  (req_raw_q),
      .rot_i  (rot_i),
      .rot_q  (rot_q)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign next_i    = acc_i_ff + {{(SUM_W-BYTE_W){1'b0}}, rot_i} - MID_CODE;
   assign next_q    = acc_q_ff + {{(SUM_W-BYTE_W){1'b0}}, rot_q} - MID_CODE;
   assign done      = {1'b0, count_ff} + DECIM_MIN;
   assign block_end = (done >= decim_ff);

   always_comb begin
      decim_in     = decim_ff;
      bypass_in    = bypass_ff;
      phase_in     = phase_ff;
      acc_i_in     = acc_i_ff;
      acc_q_in     = acc_q_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      sum_i_in     = sum_i_ff;
      sum_q_in     = sum_q_ff;

      // factor is stored already clamped to 1..256
      if (csr_write) begin
         case (csr_index)
            CSR_DECIM_FACTOR: begin
               if (csr_wdata == '0)
                  decim_in = DECIM_MIN;
               else if (csr_wdata > DECIM_MAX)
                  decim_in = DECIM_MAX;
               else
                  decim_in = csr_wdata;
            end
            CSR_ROTATION_BYPASS: bypass_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (accept) begin
         phase_in = phase_ff + 1'b1;
         if (block_end) begin
            acc_i_in     = '0;
            acc_q_in     = '0;
            count_in     = '0;
            rsp_valid_in = 1'b1;
            sum_i_in     = next_i;
            sum_q_in     = next_q;
         end else begin
            acc_i_in = next_i;
            acc_q_in = next_q;
            count_in = done[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decim_ff     <= DECIM_RESET;
         bypass_ff    <= 1'b0;
         phase_ff     <= PHASE_ONE;
         acc_i_ff     <= '0;
         acc_q_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         decim_ff     <= decim_in;
         bypass_ff    <= bypass_in;
         phase_ff     <= phase_in;
         acc_i_ff     <= acc_i_in;
         acc_q_ff     <= acc_q_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_i_ff <= sum_i_in;
      sum_q_ff <= sum_q_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum_i = sum_i_ff;
   assign rsp_sum_q = sum_q_ff;

endmodule
